// File: rtl/ppp_tx_pkg.sv
// Shared constants, types and helper functions for the PPP asynchronous frame transmitter.
// This file has no dependencies; rtl/ppp_async_frame_transmitter.sv uses it.
package ppp_tx_pkg;

  localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
  localparam logic [7:0]  ESC_BYTE      = 8'h7D;
  localparam logic [7:0]  ESC_XOR       = 8'h20;
  localparam logic [15:0] FCS_INIT      = 16'hFFFF;
  localparam logic [15:0] FCS_POLY      = 16'h8408;
  localparam logic [31:0] ESC_MAP_RESET = 32'h0002_0000;

  // The longest burst one transaction can cause: an opening flag, an escaped byte,
  // two escaped FCS bytes, and a closing flag.
  localparam int unsigned MAX_BURST = 8;
  localparam int unsigned IDX_W     = $clog2(MAX_BURST);
  localparam int unsigned CNT_W     = $clog2(MAX_BURST + 1);

  typedef logic [MAX_BURST-1:0][7:0] burst_bytes_t;
  typedef logic [IDX_W-1:0]          burst_idx_t;
  typedef logic [CNT_W-1:0]          burst_cnt_t;

  // Advance the reflected CRC-16 by one byte, processing one bit per step.
  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] v;
    v = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ FCS_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  // A flag byte and an escape byte are always escaped. A control byte below 0x20
  // is escaped when its bit is set in the map.
  function automatic logic needs_escape(input logic [7:0] b, input logic [31:0] esc_map);
    logic r;
    r = 1'b0;
    if ((b == FLAG_BYTE) || (b == ESC_BYTE)) begin
      r = 1'b1;
    end else if (b[7:5] == 3'b000) begin
      r = esc_map[b[4:0]];
    end
    return r;
  endfunction

endpackage

// File: rtl/ppp_async_frame_transmitter.sv
// PPP asynchronous frame transmitter: HDLC-like byte stuffing with a running FCS-16.
// This module depends on rtl/ppp_tx_pkg.sv for constants, burst types, FCS and escape helpers.
//
//  Channel | Ports                                   | Direction | Transaction
//  --------+-----------------------------------------+-----------+---------------------------
//  input   | in_valid, in_stall, in_data_byte,       | in        | one raw frame byte
//          | in_last_byte                            |           |
//  output  | out_valid, out_stall, out_line_byte,    | out       | one byte for the serial
//          | out_run_end                             |           | line
//  config  | cfg_wen, cfg_wdata                      | in        | write escape map (ACCM)
//
// An accepted byte is expanded in the cycle it is taken. The block writes a burst of one to
// eight line bytes into a pending buffer, and it updates the FCS and the frame-open bit.
// The pending burst moves to the drain buffer once that buffer is empty or about to send its
// last byte. The drain sends one line byte per cycle unless the output stalls. The input can
// take a new byte while the previous burst still drains, once the pending buffer is empty.
// The synchronous active-low reset empties both buffers and closes any open frame. It sets
// the FCS to 0xFFFF and the escape map to 0x00020000. A stall on the output holds the current
// line byte. A full pending buffer then stalls the input.
module ppp_async_frame_transmitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_line_byte,
  output logic        out_run_end,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata
);

  // Configuration and per-frame state.
  logic [31:0] esc_map_r;
  logic [15:0] fcs_r, fcs_nxt;
  logic        in_frame_r, in_frame_nxt;

  // The pending buffer holds a burst that has been built but not yet handed to the drain.
  logic                    p_valid_r;
  ppp_tx_pkg::burst_bytes_t p_bytes_r;
  ppp_tx_pkg::burst_cnt_t   p_cnt_r;

  // The drain buffer holds the burst that is going out, one byte per cycle while the output does not stall.
  logic                    d_valid_r;
  ppp_tx_pkg::burst_bytes_t d_bytes_r;
  ppp_tx_pkg::burst_cnt_t   d_cnt_r;
  ppp_tx_pkg::burst_idx_t   d_idx_r;

  // Burst assembly for the incoming byte.
  ppp_tx_pkg::burst_bytes_t bld_bytes;
  ppp_tx_pkg::burst_cnt_t   bld_cnt;

  logic in_acc, out_acc, d_last, drain_free, move;

  assign in_stall = p_valid_r;
  assign in_acc   = in_valid && !p_valid_r;

  assign out_valid     = d_valid_r;
  assign out_line_byte = d_bytes_r[d_idx_r];
  assign d_last        = ({1'b0, d_idx_r} == (d_cnt_r - ppp_tx_pkg::burst_cnt_t'(1)));
  assign out_run_end   = d_last;
  assign out_acc       = d_valid_r && !out_stall;

  assign drain_free = !d_valid_r || (out_acc && d_last);
  assign move       = p_valid_r && drain_free;

  // Build the line bytes for one frame byte. Each byte is placed at the next free slot.
  always_comb begin
    logic [15:0] fcs_base;
    logic [15:0] fcs_new;
    logic [15:0] fcs_out;
    logic [7:0]  seg [3];
    logic [2:0]  seg_on;
    fcs_base = in_frame_r ? fcs_r : ppp_tx_pkg::FCS_INIT;
    fcs_new  = ppp_tx_pkg::fcs_update(fcs_base, in_data_byte);
    fcs_out  = fcs_new ^ ppp_tx_pkg::FCS_INIT;
    seg[0]   = in_data_byte;
    seg[1]   = fcs_out[7:0];
    seg[2]   = fcs_out[15:8];
    seg_on   = {in_last_byte, in_last_byte, 1'b1};

    bld_bytes = '0;
    bld_cnt   = '0;
    if (!in_frame_r) begin
      bld_bytes[bld_cnt[ppp_tx_pkg::IDX_W-1:0]] = ppp_tx_pkg::FLAG_BYTE;
      bld_cnt = bld_cnt + ppp_tx_pkg::burst_cnt_t'(1);
    end
    for (int s = 0; s < 3; s++) begin
      if (seg_on[s]) begin
        if (ppp_tx_pkg::needs_escape(seg[s], esc_map_r)) begin
          bld_bytes[bld_cnt[ppp_tx_pkg::IDX_W-1:0]] = ppp_tx_pkg::ESC_BYTE;
          bld_cnt = bld_cnt + ppp_tx_pkg::burst_cnt_t'(1);
          bld_bytes[bld_cnt[ppp_tx_pkg::IDX_W-1:0]] = seg[s] ^ ppp_tx_pkg::ESC_XOR;
        end else begin
          bld_bytes[bld_cnt[ppp_tx_pkg::IDX_W-1:0]] = seg[s];
        end
        bld_cnt = bld_cnt + ppp_tx_pkg::burst_cnt_t'(1);
      end
    end
    if (in_last_byte) begin
      bld_bytes[bld_cnt[ppp_tx_pkg::IDX_W-1:0]] = ppp_tx_pkg::FLAG_BYTE;
      bld_cnt = bld_cnt + ppp_tx_pkg::burst_cnt_t'(1);
    end

    // The last byte closes the frame, and the FCS restarts for the next frame.
    if (in_last_byte) begin
      fcs_nxt      = ppp_tx_pkg::FCS_INIT;
      in_frame_nxt = 1'b0;
    end else begin
      fcs_nxt      = fcs_new;
      in_frame_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_map_r  <= ppp_tx_pkg::ESC_MAP_RESET;
      fcs_r      <= ppp_tx_pkg::FCS_INIT;
      in_frame_r <= 1'b0;
      p_valid_r  <= 1'b0;
      d_valid_r  <= 1'b0;
      d_idx_r    <= '0;
    end else begin
      if (cfg_wen) begin
        esc_map_r <= cfg_wdata;
      end
      if (in_acc) begin
        fcs_r      <= fcs_nxt;
        in_frame_r <= in_frame_nxt;
        p_valid_r  <= 1'b1;
      end else if (move) begin
        p_valid_r <= 1'b0;
      end
      if (move) begin
        d_valid_r <= 1'b1;
        d_idx_r   <= '0;
      end else if (out_acc) begin
        if (d_last) begin
          d_valid_r <= 1'b0;
        end else begin
          d_idx_r <= d_idx_r + ppp_tx_pkg::burst_idx_t'(1);
        end
      end
    end
  end

  // Burst payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_bytes_r <= bld_bytes;
      p_cnt_r   <= bld_cnt;
    end
    if (move) begin
      d_bytes_r <= p_bytes_r;
      d_cnt_r   <= p_cnt_r;
    end
  end

endmodule

// File: bench/ppp_async_frame_transmitter_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the PPP asynchronous frame transmitter: predicts line bytes and compares them.
// Depends on rtl/ppp_tx_pkg.sv for the flag, escape and FCS constants.
module ppp_async_frame_transmitter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_line_byte,
  input  logic        out_run_end,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  output int          failures,
  output int          lines_outstanding
);

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
  } line_entry_t;

  line_entry_t line_due[$];
  logic [31:0] accm = ppp_tx_pkg::ESC_MAP_RESET;
  logic [15:0] running_fcs = ppp_tx_pkg::FCS_INIT;
  logic        frame_open = 1'b0;
  int          mismatch_total = 0;

  assign failures = mismatch_total;

  function automatic logic [15:0] next_fcs(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] acc;
    logic        feedback;
    acc = fcs;
    for (int i = 0; i < 8; i++) begin
      feedback = acc[0] ^ b[i];
      acc = {1'b0, acc[15:1]};
      if (feedback) begin
        acc = acc ^ ppp_tx_pkg::FCS_POLY;
      end
    end
    return acc;
  endfunction

  function automatic logic is_escaped(input logic [7:0] b, input logic [31:0] map);
    return (b == ppp_tx_pkg::FLAG_BYTE) || (b == ppp_tx_pkg::ESC_BYTE) ||
           ((b < 8'h20) && map[b[4:0]]);
  endfunction

  // Expands one accepted frame byte into the line bytes it must produce.
  task automatic expand_frame_byte(input logic [7:0] data, input logic last);
    logic [7:0] raw[$];
    logic [7:0] burst[$];
    logic [15:0] fcs_out;
    if (!frame_open) begin
      running_fcs = ppp_tx_pkg::FCS_INIT;
      burst.push_back(ppp_tx_pkg::FLAG_BYTE);
      frame_open = 1'b1;
    end
    running_fcs = next_fcs(running_fcs, data);
    raw.push_back(data);
    if (last) begin
      fcs_out = ~running_fcs;
      raw.push_back(fcs_out[7:0]);
      raw.push_back(fcs_out[15:8]);
    end
    foreach (raw[i]) begin
      if (is_escaped(raw[i], accm)) begin
        burst.push_back(ppp_tx_pkg::ESC_BYTE);
        burst.push_back(raw[i] ^ ppp_tx_pkg::ESC_XOR);
      end else begin
        burst.push_back(raw[i]);
      end
    end
    if (last) begin
      burst.push_back(ppp_tx_pkg::FLAG_BYTE);
      running_fcs = ppp_tx_pkg::FCS_INIT;
      frame_open = 1'b0;
    end
    foreach (burst[i]) begin
      line_due.push_back('{line_byte: burst[i], run_end: (i == burst.size() - 1)});
    end
  endtask

  always @(posedge clk) begin
    line_entry_t want;
    if (!rst_n) begin
      accm = ppp_tx_pkg::ESC_MAP_RESET;
      running_fcs = ppp_tx_pkg::FCS_INIT;
      frame_open = 1'b0;
      line_due.delete();
    end else begin
      if (cfg_wen) begin
        accm = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        expand_frame_byte(in_data_byte, in_last_byte);
      end
      if (out_valid && !out_stall) begin
        if (line_due.size() == 0) begin
          mismatch_total++;
          $display("%0t: unexpected line byte: expected none, got %02h run_end %0b",
                   $time, out_line_byte, out_run_end);
        end else begin
          want = line_due.pop_front();
          if (out_line_byte !== want.line_byte) begin
            mismatch_total++;
            $display("%0t: line_byte mismatch: expected %02h, got %02h",
                     $time, want.line_byte, out_line_byte);
          end
          if (out_run_end !== want.run_end) begin
            mismatch_total++;
            $display("%0t: run_end mismatch: expected %0b, got %0b",
                     $time, want.run_end, out_run_end);
          end
        end
      end
    end
    lines_outstanding <= line_due.size();
  end

endmodule

// File: bench/ppp_async_frame_transmitter_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for the PPP asynchronous frame transmitter: stimulus, flow control, verdict.
// Depends on rtl/ppp_tx_pkg.sv, rtl/ppp_async_frame_transmitter.sv and the checker in bench/.
module ppp_async_frame_transmitter_tb;

  // A run with no accepted transaction on either channel for this many cycles is hung.
  // The deliberate receiver hold-off below is far shorter than this.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RESET_CYCLES   = 12;
  localparam int N_DIRECTED     = 15;

  // Directed frames, each entry {last_byte, data_byte}. The first is a one-byte frame whose
  // only byte is a flag, so its burst carries both framing flags and an escaped byte. The long
  // frame walks the field extremes, the two always-escaped bytes, the reset-map control byte,
  // the byte just past the control range and the escape results themselves, which must go
  // out unescaped.
  localparam logic [8:0] DIRECTED_ITEMS [N_DIRECTED] = '{
    {1'b1, 8'h7E},
    {1'b0, 8'h00}, {1'b0, 8'h11}, {1'b0, 8'h1F}, {1'b0, 8'h20}, {1'b0, 8'h5D},
    {1'b0, 8'h5E}, {1'b0, 8'h7D}, {1'b0, 8'h7E}, {1'b0, 8'h80}, {1'b0, 8'hFF},
    {1'b1, 8'h55},
    {1'b1, 8'h11},
    {1'b0, 8'h7D}, {1'b1, 8'h00}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_line_byte;
  logic        out_run_end;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = 32'h0;

  int failures;
  int lines_outstanding;

  // Idle rates in percent, changed by the stimulus between phases.
  int sender_idle_pct   = 38;
  int receiver_idle_pct = 68;

  // The stimulus raises hold_req once; the receiver process then owns the hold-off count.
  logic hold_req = 1'b0;
  logic hold_served = 1'b0;
  int   hold_left = 0;

  int quiet_cycles = 0;

  always #2 clk = ~clk;

  ppp_async_frame_transmitter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_line_byte (out_line_byte),
    .out_run_end   (out_run_end),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  ppp_async_frame_transmitter_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_byte     (out_line_byte),
    .out_run_end       (out_run_end),
    .cfg_wen           (cfg_wen),
    .cfg_wdata         (cfg_wdata),
    .failures          (failures),
    .lines_outstanding (lines_outstanding)
  );

  // Line side. Exactly one nonblocking assignment to out_stall per edge. A requested hold-off
  // keeps the line stalled long enough for the pending buffer to fill and back up the input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_served) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Hang detection: any accepted transaction, or reset, restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d line bytes outstanding",
               $time, lines_outstanding);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one frame byte and returns at the edge where it is accepted. The random gap in
  // front of it leaves in_valid low; once raised, valid and payload hold until accepted.
  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid and waits until every predicted line byte has been seen. The first edge
  // lets the count from the last accepted input reach lines_outstanding.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lines_outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  // Escape map writes happen only with the block drained, so no burst straddles a change.
  task automatic write_accm(input logic [31:0] map);
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_wdata <= map;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Sends whole frames of random content until at least the requested number of bytes has
  // gone in. Most frames are short; about one in ten is long. A quarter of the bytes are
  // control characters and another quarter are flag or escape bytes, so escaping is hit
  // often. With hold_off set, the receiver is asked to stall once the phase is under way.
  task automatic run_random_frames(input int byte_quota, input bit hold_off);
    int         sent;
    int         frame_len;
    logic [7:0] b;
    sent = 0;
    while (sent < byte_quota) begin
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
      for (int i = 0; i < frame_len; i++) begin
        case ($urandom_range(0, 3))
          0: b = 8'($urandom_range(0, 31));
          1: b = $urandom_range(0, 1) ? ppp_tx_pkg::FLAG_BYTE : ppp_tx_pkg::ESC_BYTE;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b, i == frame_len - 1);
        sent++;
        if (hold_off && sent == 12) begin
          hold_req <= 1'b1;
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames run under the reset escape map, so only XON among the control
    // bytes is escaped. The sender idles less than the receiver here.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED_ITEMS[i][7:0], DIRECTED_ITEMS[i][8]);
    end

    // Every control byte escaped.
    write_accm(32'hFFFF_FFFF);
    run_random_frames(120, 1'b0);

    // No control byte escaped; the receiver now idles less than the sender.
    write_accm(32'h0000_0000);
    sender_idle_pct = 68;
    receiver_idle_pct = 38;
    run_random_frames(120, 1'b0);

    // A random map with no idling on either side, plus one long receiver hold-off while the
    // sender keeps offering bytes.
    write_accm($urandom);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    run_random_frames(110, 1'b1);

    // Drain, then give a late or extra line byte time to show up at the checker.
    wait_drained();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ppp_tx_pkg.sv
rtl/ppp_async_frame_transmitter.sv
bench/ppp_async_frame_transmitter_checker.sv
bench/ppp_async_frame_transmitter_tb.sv
